### rtl/bcp_pkg.sv
package bcp_pkg;

  localparam int CIU_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int LABEL_W  = 8;
  localparam int SLOT_IN_W = 4;
  localparam int BAND_IN_W = 3;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic REG_CLASSES_IN_USE = 1'b0;

  // table write port, addresses travel separately as their widths follow parameters
  typedef struct packed {
    logic               bound_en;
    logic               label_en;
    logic [VALUE_W-1:0] low;
    logic [VALUE_W-1:0] high;
    logic [LABEL_W-1:0] label;
  } tbl_wr_t;

  typedef struct packed {
    logic [VALUE_W-1:0] low;
    logic [VALUE_W-1:0] high;
    logic [LABEL_W-1:0] label;
  } tbl_rd_t;

  typedef struct packed {
    logic               valid;
    logic               found;
    logic [LABEL_W-1:0] pixel_class;
  } scan_res_t;

endpackage

### rtl/bcp_table.sv
module bcp_table import bcp_pkg::*; #(
  parameter int MAX_CLASSES = 16,
  parameter int MAX_BANDS   = 8
) (
  input  logic                                       clk,
  input  tbl_wr_t                                    wr,
  input  logic [$clog2(MAX_CLASSES*MAX_BANDS)-1:0]   wr_baddr,
  input  logic [$clog2(MAX_CLASSES)-1:0]             wr_slot,
  input  logic                                       rd_en,
  input  logic [$clog2(MAX_CLASSES*MAX_BANDS)-1:0]   rd_baddr,
  input  logic [$clog2(MAX_CLASSES)-1:0]             rd_slot,
  output tbl_rd_t                                    rd
);

  localparam int DEPTH = MAX_CLASSES * MAX_BANDS;

  // bounds held as {high, low} per slot and band
  logic [2*VALUE_W-1:0] bnd_mem [DEPTH];
  logic [LABEL_W-1:0]   lbl_mem [MAX_CLASSES];

  logic [2*VALUE_W-1:0] bnd_q_r;
  logic [LABEL_W-1:0]   lbl_q_r;

  always_ff @(posedge clk) begin
    if (wr.bound_en) begin
      bnd_mem[wr_baddr] <= {wr.high, wr.low};
    end
    if (wr.label_en) begin
      lbl_mem[wr_slot] <= wr.label;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      bnd_q_r <= bnd_mem[rd_baddr];
      lbl_q_r <= lbl_mem[rd_slot];
    end
  end

  assign rd.low   = bnd_q_r[VALUE_W-1:0];
  assign rd.high  = bnd_q_r[2*VALUE_W-1:VALUE_W];
  assign rd.label = lbl_q_r;

endmodule

### rtl/bcp_scan.sv
module bcp_scan import bcp_pkg::*; #(
  parameter int MAX_CLASSES = 16,
  parameter int MAX_BANDS   = 8
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic                                       in_cmd,
  input  logic [SLOT_IN_W-1:0]                       in_slot,
  input  logic [BAND_IN_W-1:0]                       in_band,
  input  logic signed [VALUE_W-1:0]                  in_box_low,
  input  logic signed [VALUE_W-1:0]                  in_box_high,
  input  logic [LABEL_W-1:0]                         in_class_label,
  input  logic signed [VALUE_W-1:0]                  in_sample,
  input  logic                                       in_last_band,
  input  logic [CIU_W-1:0]                           classes_in_use,
  output tbl_wr_t                                    wr,
  output logic [$clog2(MAX_CLASSES*MAX_BANDS)-1:0]   wr_baddr,
  output logic [$clog2(MAX_CLASSES)-1:0]             wr_slot,
  output logic                                       rd_en,
  output logic [$clog2(MAX_CLASSES*MAX_BANDS)-1:0]   rd_baddr,
  output logic [$clog2(MAX_CLASSES)-1:0]             rd_slot,
  input  tbl_rd_t                                    rd,
  output scan_res_t                                  res,
  input  logic                                       res_ready
);

  localparam int ADDR_W = $clog2(MAX_CLASSES * MAX_BANDS);
  localparam int SLOT_W = $clog2(MAX_CLASSES);
  localparam int BAND_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_CLASSES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [SLOT_W-1:0]        idx_r, idx_nxt;
  logic                     vld_d_r;
  logic [SLOT_W-1:0]        idx_d_r;
  logic [MAX_CLASSES-1:0]   flags_r, flags_nxt;
  logic                     found_r, found_nxt;
  logic [LABEL_W-1:0]       class_r, class_nxt;
  logic signed [VALUE_W-1:0] sample_r;
  logic [BAND_W-1:0]        band_r;
  logic                     band_ok_r;
  logic                     last_r;

  logic              accept;
  logic              slot_ok;
  logic              band_ok;
  logic [BAND_W-1:0] band_sel;
  logic [SLOT_W-1:0] slot_sel;
  logic              in_box;
  logic              hit;
  logic              slot_used;

  assign slot_ok  = 32'(in_slot) < MAX_CLASSES;
  assign band_ok  = 32'(in_band) < MAX_BANDS;
  assign band_sel = band_ok ? BAND_W'(in_band) : '0;
  assign slot_sel = slot_ok ? SLOT_W'(in_slot) : '0;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // load words write straight into the table
  assign wr.bound_en = accept && (in_cmd == CMD_LOAD) && slot_ok && band_ok;
  assign wr.label_en = accept && (in_cmd == CMD_LOAD) && slot_ok;
  assign wr.low      = in_box_low;
  assign wr.high     = in_box_high;
  assign wr.label    = in_class_label;
  assign wr_baddr    = ADDR_W'(32'(slot_sel) * MAX_BANDS + 32'(band_sel));
  assign wr_slot     = slot_sel;

  // one slot per cycle from the bound memory
  assign rd_en    = (state_r == S_SCAN);
  assign rd_baddr = ADDR_W'(32'(idx_r) * MAX_BANDS + 32'(band_r));
  assign rd_slot  = idx_r;

  assign in_box    = (sample_r > $signed(rd.low)) && (sample_r < $signed(rd.high));
  assign hit       = flags_r[idx_d_r] && (!band_ok_r || in_box);
  assign slot_used = 32'(idx_d_r) < 32'(classes_in_use);

  assign res.valid       = (state_r == S_DONE) && last_r;
  assign res.found       = found_r;
  assign res.pixel_class = class_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    flags_nxt = flags_r;
    found_nxt = found_r;
    class_nxt = class_r;

    if (vld_d_r) begin
      if (band_ok_r) begin
        flags_nxt[idx_d_r] = hit;
      end
      // first slot still inside wins
      if (hit && slot_used && !found_r) begin
        found_nxt = 1'b1;
        class_nxt = rd.label;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept && (in_cmd == CMD_SAMPLE)) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          class_nxt = '0;
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (res_ready) begin
          state_nxt = S_IDLE;
          flags_nxt = '1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_d_r <= 1'b0;
      flags_r <= '1;
      found_r <= 1'b0;
      class_r <= '0;
    end else begin
      state_r <= state_nxt;
      vld_d_r <= rd_en;
      flags_r <= flags_nxt;
      found_r <= found_nxt;
      class_r <= class_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    idx_d_r <= idx_r;
    if (accept && (in_cmd == CMD_SAMPLE)) begin
      sample_r  <= in_sample;
      band_r    <= band_sel;
      band_ok_r <= band_ok;
      last_r    <= in_last_band;
    end
  end

endmodule

### rtl/box_classifier_pixel.sv
// channel | direction | word                                  | handshake
// in      | input     | cmd, slot, band, bounds, label, sample | in_valid / in_stall
// out     | output    | found, pixel_class                     | out_valid / out_stall
// cfg     | input     | classes_in_use at byte address 0       | apb, pready always high
//
// a load word does not stall the input; a sample word stalls it while
// every slot's bounds for the band are read one per cycle from the single bound memory
// port and compared before the next word is taken.
// synchronous active-low reset clears control and sets all inside flags; tables
// are not cleared and must be loaded before use.
// a finished result sits in the output register while the next word is taken;
// the scan holds its result only if that register is still full and stalled.
module box_classifier_pixel import bcp_pkg::*; #(
  parameter int MAX_CLASSES = 16,
  parameter int MAX_BANDS   = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [0:0]                in_cmd,
  input  logic [SLOT_IN_W-1:0]      in_slot,
  input  logic [BAND_IN_W-1:0]      in_band,
  input  logic signed [VALUE_W-1:0] in_box_low,
  input  logic signed [VALUE_W-1:0] in_box_high,
  input  logic [LABEL_W-1:0]        in_class_label,
  input  logic signed [VALUE_W-1:0] in_sample,
  input  logic [0:0]                in_last_band,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [0:0]                out_found,
  output logic [LABEL_W-1:0]        out_pixel_class,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [2:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  localparam int ADDR_W = $clog2(MAX_CLASSES * MAX_BANDS);
  localparam int SLOT_W = $clog2(MAX_CLASSES);

  logic [CIU_W-1:0] classes_r;
  logic             cfg_wr;

  tbl_wr_t            wr;
  tbl_rd_t            rd;
  logic [ADDR_W-1:0]  wr_baddr;
  logic [SLOT_W-1:0]  wr_slot;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_baddr;
  logic [SLOT_W-1:0]  rd_slot;
  scan_res_t          res;
  logic               res_ready;

  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r;
  logic [LABEL_W-1:0] out_class_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_CLASSES_IN_USE);
  assign cfg_prdata = (cfg_paddr[2] == REG_CLASSES_IN_USE) ?
                      {{(32-CIU_W){1'b0}}, classes_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      classes_r <= '0;
    end else if (cfg_wr) begin
      classes_r <= cfg_pwdata[CIU_W-1:0];
    end
  end

  bcp_scan #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_BANDS   (MAX_BANDS)
  ) u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd[0]),
    .in_slot        (in_slot),
    .in_band        (in_band),
    .in_box_low     (in_box_low),
    .in_box_high    (in_box_high),
    .in_class_label (in_class_label),
    .in_sample      (in_sample),
    .in_last_band   (in_last_band[0]),
    .classes_in_use (classes_r),
    .wr             (wr),
    .wr_baddr       (wr_baddr),
    .wr_slot        (wr_slot),
    .rd_en          (rd_en),
    .rd_baddr       (rd_baddr),
    .rd_slot        (rd_slot),
    .rd             (rd),
    .res            (res),
    .res_ready      (res_ready)
  );

  bcp_table #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_BANDS   (MAX_BANDS)
  ) u_table (
    .clk      (clk),
    .wr       (wr),
    .wr_baddr (wr_baddr),
    .wr_slot  (wr_slot),
    .rd_en    (rd_en),
    .rd_baddr (rd_baddr),
    .rd_slot  (rd_slot),
    .rd       (rd)
  );

  // output register
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_found_r <= res.found;
      out_class_r <= res.pixel_class;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_pixel_class = out_class_r;

  // a result held back by a full output register stays offered
  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && !res_ready |=> res.valid)
    else $error("scan result dropped while output register full");

  // no label without a match
  a_class_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found == 1'b1 || out_pixel_class == '0))
    else $error("pixel_class set without a match");

  // a new word is only taken once the scan has handed its result on
  a_idle_no_res: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !res.valid && !rd_en)
    else $error("input taken while scan busy");

  // table is never written while a scan reads it
  a_no_wr_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !wr.bound_en && !wr.label_en)
    else $error("table write during scan");

endmodule
